FILE: rtl/vpsm_pkg.sv
`timescale 1ns / 1ps
// Package for the virtual PCI slot mapper: table size, opcodes, status codes,
// word types of both channels and the slot table's port structs. No dependencies.
package vpsm_pkg;

  localparam int unsigned NUM_SLOTS = 32;
  localparam int unsigned SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  localparam logic [1:0] OP_ADD     = 2'd0;
  localparam logic [1:0] OP_LOOKUP  = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BRIDGE   = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  localparam logic [7:0] BRIDGE_CLASS = 8'h06;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] req_domain;
    logic [7:0]  req_bus;
    logic [7:0]  req_devfn;
    logic [7:0]  base_class;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  virtual_slot;
    logic [15:0] phys_domain;
    logic [7:0]  phys_bus;
    logic [7:0]  phys_devfn;
  } rsp_t;

  // One write port into the slot table
  typedef struct packed {
    logic              we;
    logic              set_used;
    logic [SLOT_W-1:0] addr;
    logic [15:0]       domain;
    logic [7:0]        bus;
    logic [4:0]        dev;
    logic [7:0]        func;
  } tbl_wr_t;

  // Read data of one slot
  typedef struct packed {
    logic        used;
    logic [15:0] domain;
    logic [7:0]  bus;
    logic [4:0]  dev;
    logic [7:0]  func;
  } tbl_rd_t;

endpackage

FILE: rtl/virtual_pci_slot_mapper_unit.sv
`timescale 1ns / 1ps
// Top level of the virtual PCI slot mapper: request sequencer, slot compare
// and output register. Depends on vpsm_pkg and vpsm_table.
//
//   channel | direction | handshake                | word
//   --------+-----------+--------------------------+--------------
//   request | in        | req_valid_i / req_ready_o | vpsm_pkg::req_t
//   result  | out       | rsp_valid_o / rsp_ready_i | vpsm_pkg::rsp_t
//
// An add of a non-bridge device walks the slot table one slot a cycle through a
// single compare unit and stops early when a matching slot turns up. A lookup in
// range reads its slot in S_LOOK; release, bridge adds and unknown opcodes go to S_FIN.
// Reset clears the occupancy bits at once; the table is usable right after it.
// Requests are taken only in idle; a result waiting on rsp_ready_i holds the
// sequencer in its final state, and one result word may wait in the output register.
module virtual_pci_slot_mapper_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  vpsm_pkg::req_t req_i,
  output logic           rsp_valid_o,
  input  logic           rsp_ready_i,
  output vpsm_pkg::rsp_t rsp_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_LOOK = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  localparam logic [vpsm_pkg::SLOT_W-1:0] LAST_IDX =
    vpsm_pkg::SLOT_W'(vpsm_pkg::NUM_SLOTS - 1);

  logic [1:0]                  state_q, state_d;
  vpsm_pkg::req_t              req_q, req_d;
  logic [vpsm_pkg::SLOT_W-1:0] idx_q, idx_d;
  logic [vpsm_pkg::SLOT_W-1:0] free_q, free_d;
  logic                        free_found_q, free_found_d;
  vpsm_pkg::rsp_t              res_q, res_d;
  vpsm_pkg::rsp_t              rsp_q, rsp_d;
  logic                        rsp_valid_q, rsp_valid_d;

  vpsm_pkg::tbl_wr_t tbl_wr;
  vpsm_pkg::tbl_rd_t tbl_rd;
  logic              tbl_clear;

  logic                        accept;
  logic                        hit;
  logic                        have_free;
  logic [vpsm_pkg::SLOT_W-1:0] free_now;
  logic [7:0]                  fbit;
  logic [2:0]                  fn;
  logic                        look_ok;
  logic                        in_range;

  vpsm_table u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clear_i  (tbl_clear),
    .wr_i     (tbl_wr),
    .rd_addr_i(idx_q),
    .rd_o     (tbl_rd)
  );

  assign req_ready_o = (state_q == S_IDLE);
  assign accept      = req_valid_i && req_ready_o;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // Shared compare unit: current slot against the held request
  assign fn        = req_q.req_devfn[2:0];
  assign fbit      = 8'(1) << fn;
  assign hit       = tbl_rd.used && (tbl_rd.domain == req_q.req_domain) &&
                     (tbl_rd.bus == req_q.req_bus) && (tbl_rd.dev == req_q.req_devfn[7:3]);
  assign have_free = free_found_q || !tbl_rd.used;
  assign free_now  = free_found_q ? free_q : idx_q;
  assign look_ok   = tbl_rd.used && tbl_rd.func[fn];
  assign in_range  = {1'b0, req_i.req_devfn[7:3]} < 6'(vpsm_pkg::NUM_SLOTS);

  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    idx_d        = idx_q;
    free_d       = free_q;
    free_found_d = free_found_q;
    res_d        = res_q;
    rsp_d        = rsp_q;
    rsp_valid_d  = rsp_valid_q;
    tbl_clear    = 1'b0;
    tbl_wr       = '0;
    tbl_wr.addr  = idx_q;

    if (rsp_valid_q && rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_d        = req_i;
          idx_d        = '0;
          free_found_d = 1'b0;
          res_d        = '0;
          state_d      = S_FIN;
          unique case (req_i.opcode)
            vpsm_pkg::OP_ADD: begin
              if (req_i.base_class == vpsm_pkg::BRIDGE_CLASS) begin
                res_d.status = vpsm_pkg::ST_BRIDGE;
              end else begin
                state_d = S_SCAN;
              end
            end
            vpsm_pkg::OP_LOOKUP: begin
              if (req_i.req_domain == 16'd0 && req_i.req_bus == 8'd0 && in_range) begin
                idx_d   = vpsm_pkg::SLOT_W'(req_i.req_devfn[7:3]);
                state_d = S_LOOK;
              end else begin
                res_d.status = vpsm_pkg::ST_NOTFOUND;
              end
            end
            vpsm_pkg::OP_RELEASE: begin
              tbl_clear    = 1'b1;
              res_d.status = vpsm_pkg::ST_OK;
            end
            default: begin
              res_d.status = vpsm_pkg::ST_NOTFOUND;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (hit) begin
          // Join the occupied slot
          tbl_wr.we          = 1'b1;
          tbl_wr.addr        = idx_q;
          tbl_wr.domain      = tbl_rd.domain;
          tbl_wr.bus         = tbl_rd.bus;
          tbl_wr.dev         = tbl_rd.dev;
          tbl_wr.func        = tbl_rd.func | fbit;
          res_d.status       = vpsm_pkg::ST_OK;
          res_d.virtual_slot = 5'(idx_q);
          state_d            = S_FIN;
        end else if (idx_q == LAST_IDX) begin
          if (have_free) begin
            tbl_wr.we          = 1'b1;
            tbl_wr.set_used    = 1'b1;
            tbl_wr.addr        = free_now;
            tbl_wr.domain      = req_q.req_domain;
            tbl_wr.bus         = req_q.req_bus;
            tbl_wr.dev         = req_q.req_devfn[7:3];
            tbl_wr.func        = fbit;
            res_d.status       = vpsm_pkg::ST_OK;
            res_d.virtual_slot = 5'(free_now);
          end else begin
            res_d.status = vpsm_pkg::ST_FULL;
          end
          state_d = S_FIN;
        end else begin
          // Remember the lowest empty slot, advance
          if (!free_found_q && !tbl_rd.used) begin
            free_d       = idx_q;
            free_found_d = 1'b1;
          end
          idx_d = idx_q + 1'b1;
        end
      end
      S_LOOK: begin
        if (look_ok) begin
          res_d.status       = vpsm_pkg::ST_OK;
          res_d.virtual_slot = 5'(idx_q);
          res_d.phys_domain  = tbl_rd.domain;
          res_d.phys_bus     = tbl_rd.bus;
          res_d.phys_devfn   = {tbl_rd.dev, fn};
        end else begin
          res_d.status = vpsm_pkg::ST_NOTFOUND;
        end
        state_d = S_FIN;
      end
      S_FIN: begin
        // Hold until the output register is free
        if (!rsp_valid_q || rsp_ready_i) begin
          rsp_d       = res_q;
          rsp_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      rsp_valid_q  <= 1'b0;
      free_found_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      rsp_valid_q  <= rsp_valid_d;
      free_found_q <= free_found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    idx_q  <= idx_d;
    free_q <= free_d;
    res_q  <= res_d;
    rsp_q  <= rsp_d;
  end

endmodule

FILE: rtl/vpsm_table.sv
`timescale 1ns / 1ps
// Slot table of the virtual PCI slot mapper: one read and one write address.
// Occupancy bits reset and clear at once; slot contents count only when occupied.
// Depends on vpsm_pkg.
module vpsm_table (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        clear_i,
  input  vpsm_pkg::tbl_wr_t           wr_i,
  input  logic [vpsm_pkg::SLOT_W-1:0] rd_addr_i,
  output vpsm_pkg::tbl_rd_t           rd_o
);

  logic [vpsm_pkg::NUM_SLOTS-1:0] used_q;
  logic [15:0] domain_q [vpsm_pkg::NUM_SLOTS];
  logic [7:0]  bus_q    [vpsm_pkg::NUM_SLOTS];
  logic [4:0]  dev_q    [vpsm_pkg::NUM_SLOTS];
  logic [7:0]  func_q   [vpsm_pkg::NUM_SLOTS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (clear_i) begin
      used_q <= '0;
    end else if (wr_i.we && wr_i.set_used) begin
      used_q[wr_i.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      domain_q[wr_i.addr] <= wr_i.domain;
      bus_q[wr_i.addr]    <= wr_i.bus;
      dev_q[wr_i.addr]    <= wr_i.dev;
      func_q[wr_i.addr]   <= wr_i.func;
    end
  end

  always_comb begin
    rd_o.used   = used_q[rd_addr_i];
    rd_o.domain = domain_q[rd_addr_i];
    rd_o.bus    = bus_q[rd_addr_i];
    rd_o.dev    = dev_q[rd_addr_i];
    rd_o.func   = func_q[rd_addr_i];
  end

endmodule
